### rtl/core/owpt_pkg.sv
// ----------------------------------------------------------------------------
// owpt_pkg
// Shared codes and constants of the one-wire pulse-width transmitter.
// ----------------------------------------------------------------------------
package owpt_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_START_HIGH = 3'd0,
		REG_START_LOW  = 3'd1,
		REG_LONG       = 3'd2,
		REG_SHORT      = 3'd3,
		REG_BUSY_WAIT  = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_SEND_MODE  = 2'd1,
		OP_SEND_FRAME = 2'd2,
		OP_RESERVED   = 2'd3
	} op_t;

	localparam logic [7:0] FRAME_HEAD_BYTE = 8'h0A;
	localparam logic [7:0] DECIMAL_BASE    = 8'd10;
	localparam logic [7:0] DIV10_MUL       = 8'd205;
	localparam int unsigned DIV10_SHIFT    = 11;

	localparam logic [15:0] RST_START_HIGH = 16'd100;
	localparam logic [15:0] RST_START_LOW  = 16'd3000;
	localparam logic [15:0] RST_LONG       = 16'd1500;
	localparam logic [15:0] RST_SHORT      = 16'd500;

	localparam int unsigned OUT_LINE_BIT = 0;
	localparam int unsigned OUT_IDLE_BIT = 1;
	localparam int unsigned OUT_ACC_BIT  = 2;

endpackage

### rtl/core/one_wire_pulse_width_transmitter.sv
// ----------------------------------------------------------------------------
// one_wire_pulse_width_transmitter
// Pulse-width encoder for an idle-high control line, advanced by tick beats.
// ----------------------------------------------------------------------------
// The result beat of each input beat is written to the output register when the beat is taken.
// Throughput: one beat per cycle unless a result is stalled; the output register lets a
// new beat enter while the previous result is taken in the same cycle.
// Reset: asynchronous, active low; the line idles high, the queue is empty and
// the timing registers take their default values.
// ----------------------------------------------------------------------------
module one_wire_pulse_width_transmitter
	import owpt_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [7:0] number, [15:8] mode_byte, [16] busy_line, [23:17] zero
	input  logic [23:0]           s_tdata,
	// [1:0] op
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] line_level, [1] idle, [2] accepted, [7:3] zero
	output logic [7:0]            m_tdata
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT,
		PH_START_HIGH,
		PH_START_LOW,
		PH_BIT_HIGH,
		PH_BIT_LOW
	} phase_t;

	function automatic logic [15:0] dur(input logic [15:0] v);
		dur = (v == 16'd0) ? 16'd1 : v;
	endfunction

	logic [15:0] start_high_q, start_low_q, long_q, short_q;
	logic        busy_wait_q;

	phase_t             phase_q, phase_d;
	logic [15:0]        timer_q, timer_d;
	logic [2:0]         bit_q, bit_d;
	logic [7:0]         shift_q, shift_d;
	logic [7:0]         queue_q [QUEUE_DEPTH];
	logic [7:0]         queue_d [QUEUE_DEPTH];
	logic [CNT_W-1:0]   count_q, count_d;
	logic               line_q, line_d;
	logic               out_valid_q;
	logic [7:0]         out_data_q;

	logic        take;
	logic        is_idle;
	logic        is_req;
	logic [7:0]  number;
	logic [7:0]  mode_byte;
	logic        busy_line;
	logic [15:0] div_prod;
	logic [7:0]  tens;
	logic [7:0]  units;
	logic [7:0]  fb [4];
	logic [CNT_W-1:0] fn;
	logic        o_line, o_idle, o_acc;
	logic [7:0]  o_data;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign number    = s_tdata[7:0];
	assign mode_byte = s_tdata[15:8];
	assign busy_line = s_tdata[16];
	assign is_req    = (s_tuser == OP_SEND_MODE) || (s_tuser == OP_SEND_FRAME);
	assign is_idle   = (phase_q == PH_IDLE) && (count_q == '0);

	assign div_prod = 16'(number) * 16'(DIV10_MUL);
	assign tens     = 8'(div_prod >> DIV10_SHIFT);
	assign units    = number - 8'((tens << 3) + (tens << 1));

	always_comb begin
		fb[0] = mode_byte;
		fb[1] = mode_byte;
		fb[2] = mode_byte;
		fb[3] = mode_byte;
		fn    = CNT_W'(1);
		if (s_tuser == OP_SEND_FRAME) begin
			fb[0] = FRAME_HEAD_BYTE;
			if (number < DECIMAL_BASE) begin
				fb[1] = number;
				fn    = CNT_W'(3);
			end else begin
				fb[1] = tens;
				fb[2] = units;
				fn    = CNT_W'(4);
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		count_d = count_q;
		line_d  = line_q;
		queue_d = queue_q;
		o_line  = line_q;
		o_idle  = is_idle;
		o_acc   = 1'b0;
		if (take) begin
			if (is_req) begin
				if (is_idle) begin
					o_acc  = 1'b1;
					line_d = 1'b1;
					if (busy_wait_q && busy_line) begin
						phase_d = PH_WAIT;
						for (int i = 0; i < 4; i++) begin
							queue_d[i] = fb[i];
						end
						count_d = fn;
					end else begin
						shift_d = fb[0];
						for (int i = 0; i < 3; i++) begin
							queue_d[i] = fb[i+1];
						end
						count_d = fn - CNT_W'(1);
						bit_d   = 3'd0;
						phase_d = PH_START_HIGH;
						timer_d = dur(start_high_q);
					end
				end
				o_line = line_d;
				o_idle = (phase_d == PH_IDLE) && (count_d == '0);
			end else begin
				case (phase_q)
					PH_IDLE: begin
					end
					PH_WAIT: begin
						if (!busy_line) begin
							if (count_q != '0) begin
								shift_d = queue_q[0];
								for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
									queue_d[i] = queue_q[i+1];
								end
								count_d = count_q - CNT_W'(1);
								bit_d   = 3'd0;
								phase_d = PH_START_HIGH;
								line_d  = 1'b1;
								timer_d = dur(start_high_q);
							end else begin
								phase_d = PH_IDLE;
							end
						end
					end
					default: begin
						if (timer_q > 16'd1) begin
							timer_d = timer_q - 16'd1;
						end else begin
							case (phase_q)
								PH_START_HIGH: begin
									phase_d = PH_START_LOW;
									line_d  = 1'b0;
									timer_d = dur(start_low_q);
								end
								PH_START_LOW: begin
									phase_d = PH_BIT_HIGH;
									line_d  = 1'b1;
									timer_d = dur(shift_q[0] ? long_q : short_q);
								end
								PH_BIT_HIGH: begin
									phase_d = PH_BIT_LOW;
									line_d  = 1'b0;
									timer_d = dur(shift_q[0] ? short_q : long_q);
								end
								default: begin
									if (bit_q == 3'd7) begin
										line_d  = 1'b1;
										timer_d = 16'd0;
										if (count_q != '0) begin
											shift_d = queue_q[0];
											for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
												queue_d[i] = queue_q[i+1];
											end
											count_d = count_q - CNT_W'(1);
											bit_d   = 3'd0;
											phase_d = PH_START_HIGH;
											timer_d = dur(start_high_q);
										end else begin
											phase_d = PH_IDLE;
										end
									end else begin
										bit_d   = bit_q + 3'd1;
										shift_d = shift_q >> 1;
										phase_d = PH_BIT_HIGH;
										line_d  = 1'b1;
										timer_d = dur(shift_q[1] ? long_q : short_q);
									end
								end
							endcase
						end
					end
				endcase
			end
		end
	end

	always_comb begin
		o_data               = 8'd0;
		o_data[OUT_LINE_BIT] = o_line;
		o_data[OUT_IDLE_BIT] = o_idle;
		o_data[OUT_ACC_BIT]  = o_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_high_q <= RST_START_HIGH;
			start_low_q  <= RST_START_LOW;
			long_q       <= RST_LONG;
			short_q      <= RST_SHORT;
			busy_wait_q  <= 1'b0;
			phase_q      <= PH_IDLE;
			timer_q      <= 16'd0;
			bit_q        <= 3'd0;
			shift_q      <= 8'd0;
			count_q      <= '0;
			line_q       <= 1'b1;
			out_valid_q  <= 1'b0;
			out_data_q   <= 8'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_START_HIGH: start_high_q <= cfg_wdata;
					REG_START_LOW:  start_low_q  <= cfg_wdata;
					REG_LONG:       long_q       <= cfg_wdata;
					REG_SHORT:      short_q      <= cfg_wdata;
					REG_BUSY_WAIT:  busy_wait_q  <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			phase_q <= phase_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			count_q <= count_d;
			line_q  <= line_d;
			if (take) begin
				out_valid_q <= 1'b1;
				out_data_q  <= o_data;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		queue_q <= queue_d;
	end

endmodule

### rtl/core/owpt_checker.sv
// ----------------------------------------------------------------------------
// owpt_checker
// Port-level checks of the one-wire pulse-width transmitter.
// ----------------------------------------------------------------------------
module owpt_checker
	import owpt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	logic in_beat;
	logic in_req;

	assign in_beat = s_tvalid && s_tready;
	assign in_req  = (s_tuser == OP_SEND_MODE) || (s_tuser == OP_SEND_FRAME);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

	a_tick_not_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && !in_req |=> m_tvalid && !m_tdata[OUT_ACC_BIT])
		else $error("tick beat reported as accepted request");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && in_req |=> m_tvalid && !m_tdata[OUT_IDLE_BIT])
		else $error("request beat reported idle");

	a_acc_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && in_req |=> !m_tdata[OUT_ACC_BIT] || m_tdata[OUT_LINE_BIT])
		else $error("accepted request did not leave the line high");

endmodule

bind one_wire_pulse_width_transmitter owpt_checker u_owpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
